// File: src/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int KEY_W      = 8;
   localparam int DATA_W     = 56;
   localparam int USED_W     = 5;
   localparam int LIMIT_W    = 5;
   localparam int EXT_W      = CNT_W + USED_W;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2,
      ST_ZERO = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic read;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic out_busy;
   } stat_type;

endpackage

`default_nettype wire

// File: src/krt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module krt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire krt_pkg::stat_type stat,
   output krt_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in   = state_ff;
      ready_in   = ready_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.read   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.need_scan) begin
               state_in = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               if (stat.scan_last) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               ready_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

`default_nettype wire

// File: src/krt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module krt_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [krt_pkg::KEY_W-1:0]     req_key,
   input  wire logic [krt_pkg::DATA_W-1:0]    req_payload,
   input  wire logic                          csr_write,
   input  wire logic [krt_pkg::LIMIT_W-1:0]   csr_limit,
   input  wire krt_pkg::cmd_type              cmd,
   output krt_pkg::stat_type                  stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [krt_pkg::DATA_W-1:0]         rsp_payload,
   output logic [krt_pkg::USED_W-1:0]         rsp_used,
   output logic                               rsp_full
);

   // request capture
   logic [1:0]                    op_ff;
   logic [krt_pkg::KEY_W-1:0]     key_ff;
   logic [krt_pkg::DATA_W-1:0]    pay_ff;

   // table: keys in flops (cleared at reset), record bytes in memory
   logic [krt_pkg::KEY_W-1:0]     keys_ff [krt_pkg::SLOT_COUNT];
   logic [krt_pkg::DATA_W-1:0]    mem [krt_pkg::SLOT_COUNT];
   logic [krt_pkg::DATA_W-1:0]    rd_ff;

   // scan state
   logic [krt_pkg::IDX_W-1:0]     idx_ff;
   logic [krt_pkg::IDX_W-1:0]     slot_ff;
   logic                          hit_ff;
   logic [krt_pkg::CNT_W-1:0]     hits_ff;

   logic [krt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [krt_pkg::LIMIT_W-1:0]   limit_ff;

   logic                          out_valid_ff;
   logic [1:0]                    out_status_ff, out_status_in;
   logic [krt_pkg::DATA_W-1:0]    out_pay_ff, out_pay_in;
   logic [krt_pkg::USED_W-1:0]    out_used_ff;
   logic                          out_full_ff;

   logic [krt_pkg::KEY_W-1:0]     cur_key;
   logic                          cur_match, cur_free;
   logic                          is_full;
   logic                          do_insert;
   logic [krt_pkg::EXT_W-1:0]     count_ext, new_ext, limit_ext;

   assign cur_key   = keys_ff[idx_ff];
   assign cur_match = (cur_key == key_ff);
   assign cur_free  = (cur_key == '0);

   assign count_ext = {{krt_pkg::USED_W{1'b0}}, count_ff};
   assign limit_ext = {{krt_pkg::CNT_W{1'b0}}, limit_ff};
   assign is_full   = (count_ext >= limit_ext) || !hit_ff;

   assign stat.need_scan = (key_ff != '0) && (op_ff != krt_pkg::OP_UNUSED);
   assign stat.scan_last = (idx_ff == krt_pkg::IDX_W'(krt_pkg::SLOT_COUNT - 1));
   assign stat.out_busy  = out_valid_ff && !rsp_ready;

   // commit decision
   always_comb begin
      count_in      = count_ff;
      out_status_in = krt_pkg::ST_DONE;
      out_pay_in    = '0;
      do_insert     = 1'b0;
      if (key_ff == '0) begin
         out_status_in = krt_pkg::ST_ZERO;
      end else begin
         case (op_ff)
            krt_pkg::OP_INSERT: begin
               if (is_full) begin
                  out_status_in = krt_pkg::ST_FULL;
               end else begin
                  do_insert = 1'b1;
                  count_in  = krt_pkg::CNT_W'(count_ff + 1'b1);
               end
            end
            krt_pkg::OP_REMOVE: begin
               if (hits_ff == '0) begin
                  out_status_in = krt_pkg::ST_MISS;
               end
               count_in = (hits_ff > count_ff) ? '0 : krt_pkg::CNT_W'(count_ff - hits_ff);
            end
            krt_pkg::OP_LOOKUP: begin
               if (hit_ff) begin
                  out_pay_in = rd_ff;
               end else begin
                  out_status_in = krt_pkg::ST_MISS;
               end
            end
            default: begin
               out_status_in = krt_pkg::ST_DONE;
            end
         endcase
      end
   end

   assign new_ext = {{krt_pkg::USED_W{1'b0}}, count_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < krt_pkg::SLOT_COUNT; i++) begin
            keys_ff[i] <= '0;
         end
         count_ff     <= '0;
         limit_ff     <= krt_pkg::LIMIT_RESET;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         hits_ff      <= '0;
      end else begin
         if (csr_write) begin
            limit_ff <= csr_limit;
         end
         if (cmd.load) begin
            idx_ff  <= '0;
            hit_ff  <= 1'b0;
            hits_ff <= '0;
         end
         if (cmd.step) begin
            idx_ff <= krt_pkg::IDX_W'(idx_ff + 1'b1);
            case (op_ff)
               krt_pkg::OP_INSERT: begin
                  if (cur_free && !hit_ff) begin
                     hit_ff <= 1'b1;
                  end
               end
               krt_pkg::OP_REMOVE: begin
                  if (cur_match) begin
                     keys_ff[idx_ff] <= '0;
                     hits_ff         <= krt_pkg::CNT_W'(hits_ff + 1'b1);
                  end
               end
               krt_pkg::OP_LOOKUP: begin
                  if (cur_match && !hit_ff) begin
                     hit_ff <= 1'b1;
                  end
               end
               default: begin
                  hit_ff <= hit_ff;
               end
            endcase
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            out_valid_ff <= 1'b1;
            if (do_insert) begin
               keys_ff[slot_ff] <= key_ff;
            end
         end else if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      if (cmd.step && !hit_ff) begin
         if (((op_ff == krt_pkg::OP_INSERT) && cur_free) ||
             ((op_ff == krt_pkg::OP_LOOKUP) && cur_match)) begin
            slot_ff <= idx_ff;
         end
      end
      if (cmd.read) begin
         rd_ff <= mem[slot_ff];
      end
      if (cmd.finish && do_insert) begin
         mem[slot_ff] <= pay_ff;
      end
      if (cmd.finish) begin
         out_status_ff <= out_status_in;
         out_pay_ff    <= out_pay_in;
         out_used_ff   <= new_ext[krt_pkg::USED_W-1:0];
         out_full_ff   <= (new_ext >= limit_ext);
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_payload = out_pay_ff;
   assign rsp_used    = out_used_ff;
   assign rsp_full    = out_full_ff;

endmodule

`default_nettype wire

// File: src/keyed_record_table.sv
// Insert, remove and lookup scan all 16 slots, then do one memory read and one commit;
//   key zero or the unused opcode skips the scan and read. The key flops are scanned one
//   slot per cycle. No new request beat is taken until the last request commits; a
//   response waiting in the output register does not block the next request beat but
//   holds its commit. Reset is synchronous, active high: every slot is freed at once,
//   the used count clears and the capacity limit returns to 10.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table (
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // key[7:0], year_in[15:8], course1_id_in[23:16], course1_grade_in[31:24],
   // course2_id_in[39:32], course2_grade_in[47:40], course3_id_in[55:48],
   // course3_grade_in[63:56]
   input  wire logic [63:0] req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]  req_tuser,

   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // year_out[7:0], course1_id_out[15:8], course1_grade_out[23:16],
   // course2_id_out[31:24], course2_grade_out[39:32], course3_id_out[47:40],
   // course3_grade_out[55:48], used_count[60:56], full_flag[61], zero[63:62]
   output logic [63:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]       rsp_tuser,

   // capacity limit write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data
);

   krt_pkg::cmd_type                   cmd;
   krt_pkg::stat_type                  stat;
   logic [krt_pkg::DATA_W-1:0]         rsp_payload;
   logic [krt_pkg::USED_W-1:0]         rsp_used;
   logic                               rsp_full;

   // the limit register takes a write beat in any cycle
   assign csr_ready = 1'b1;

   // sequencer: accept, scan, read, commit
   krt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table, counters and output register
   krt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_opcode  (req_tuser),
      .req_key     (req_tdata[7:0]),
      .req_payload (req_tdata[63:8]),
      .csr_write   (csr_valid),
      .csr_limit   (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_payload (rsp_payload),
      .rsp_used    (rsp_used),
      .rsp_full    (rsp_full)
   );

   // pack the response beat, pad the top two bits
   assign rsp_tdata = {2'b00, rsp_full, rsp_used, rsp_payload};

endmodule

`default_nettype wire
